[rtl/core/lkvt_pkg.sv]
// ----------------------------------------------------------------------------
// lkvt_pkg: shared types of the linear key/value table
// Request and result formats, operation and status codes, and the fixed
// widths of the request and result fields.
// ----------------------------------------------------------------------------
package lkvt_pkg;

  localparam int DATA_W  = 32;
  localparam int INDEX_W = 4;
  localparam int FILL_W  = 5;

  localparam logic [1:0] REQ_PUT    = 2'd0;
  localparam logic [1:0] REQ_GET    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef struct packed {
    op_e                 op;
    logic                search;
    logic [DATA_W-1:0]   key;
    logic [DATA_W-1:0]   value;
    logic [INDEX_W-1:0]  index;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   out_value;
    logic [DATA_W-1:0]   out_key;
    logic [FILL_W-1:0]   fill_count;
  } res_t;

endpackage

[rtl/core/linear_key_value_table_top.sv]
// ----------------------------------------------------------------------------
// linear_key_value_table_top: ordered key/value table
// Top level joining the request intake, the table engine and the result
// buffer.
// ----------------------------------------------------------------------------
// The table holds up to CAPACITY key/value pairs in insertion order and
// answers each request with exactly one result. Requests are decoded and
// queued on entry, and the engine takes one at a time from that queue. The
// engine walks the key and value storage, which has one read port and one
// write port, one entry per cycle. A put or get stops at the position where
// its key is found. A remove covers every stored pair wherever the key
// sits: it scans up to the key and then shifts the pairs behind it down
// by one place. A miss also scans every stored pair, and a read by index
// reads its one entry without a walk. The walk over the stored pairs thus
// sets how long a request takes, and a full table gives the longest walk.
// Results wait in a two-entry buffer, so new requests are queued while
// earlier results are still waiting to be popped.
module linear_key_value_table_top #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    req_type_i,
  input  logic [lkvt_pkg::DATA_W-1:0]   key_i,
  input  logic [lkvt_pkg::DATA_W-1:0]   value_i,
  input  logic [lkvt_pkg::INDEX_W-1:0]  index_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    status_o,
  output logic [lkvt_pkg::DATA_W-1:0]   out_value_o,
  output logic [lkvt_pkg::DATA_W-1:0]   out_key_o,
  output logic [lkvt_pkg::FILL_W-1:0]   fill_count_o
);

  lkvt_pkg::req_t req;
  lkvt_pkg::res_t res_eng;
  lkvt_pkg::res_t res_out;
  logic           req_valid, req_pop;
  logic           res_push, res_full;

  lkvt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .index_i     (index_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop)
  );

  lkvt_back #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_eng)
  );

  lkvt_result_queue u_result_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_eng),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_out)
  );

  assign status_o     = res_out.status;
  assign out_value_o  = res_out.out_value;
  assign out_key_o    = res_out.out_key;
  assign fill_count_o = res_out.fill_count;

endmodule

[rtl/core/lkvt_front.sv]
// ----------------------------------------------------------------------------
// lkvt_front: request intake
// Accepts requests, decodes the request type and holds decoded requests in
// a two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
module lkvt_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        req_type_i,
  input  logic [lkvt_pkg::DATA_W-1:0]       key_i,
  input  logic [lkvt_pkg::DATA_W-1:0]       value_i,
  input  logic [lkvt_pkg::INDEX_W-1:0]      index_i,
  output logic                              req_valid_o,
  output lkvt_pkg::req_t                    req_o,
  input  logic                              req_pop_i
);

  lkvt_pkg::req_t slot_q [2];
  lkvt_pkg::req_t decoded;
  logic [1:0]     used_q, used_d;
  logic           wr_q, rd_q;
  logic           do_push, do_pop;

  always_comb begin
    decoded.key    = key_i;
    decoded.value  = value_i;
    decoded.index  = index_i;
    decoded.search = 1'b1;
    case (req_type_i)
      lkvt_pkg::REQ_PUT:    decoded.op = lkvt_pkg::OP_PUT;
      lkvt_pkg::REQ_GET:    decoded.op = lkvt_pkg::OP_GET;
      lkvt_pkg::REQ_REMOVE: decoded.op = lkvt_pkg::OP_REMOVE;
      lkvt_pkg::REQ_READ: begin
        decoded.op     = lkvt_pkg::OP_READ;
        decoded.search = 1'b0;
      end
      default: begin
        decoded.op     = lkvt_pkg::OP_READ;
        decoded.search = 1'b0;
      end
    endcase
  end

  assign full        = (used_q == 2'd2);
  assign req_valid_o = (used_q != 2'd0);
  assign req_o       = slot_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = req_pop_i && req_valid_o;
  assign used_d      = 2'(used_q + 2'(do_push) - 2'(do_pop));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 2'd0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
    end else begin
      used_q <= used_d;
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= decoded;
  end

endmodule

[rtl/core/lkvt_back.sv]
// ----------------------------------------------------------------------------
// lkvt_back: table engine
// Walks the key and value storage one entry per cycle to serve put, get and
// remove requests, closes the gap after a remove, and serves reads by index.
// ----------------------------------------------------------------------------
module lkvt_back #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  lkvt_pkg::req_t  req_i,
  output logic            req_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output lkvt_pkg::res_t  res_o
);

  localparam int KW = (KEY_BITS < lkvt_pkg::DATA_W) ? KEY_BITS : lkvt_pkg::DATA_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > lkvt_pkg::INDEX_W) ? CW : lkvt_pkg::INDEX_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_READ  = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  lkvt_pkg::req_t               cur_q, cur_d;
  logic [CW-1:0]                ptr_q, ptr_d;
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                ptr_next, ptr_prev;
  logic                         more, in_range, match;

  logic [KW-1:0]                key_mem [CAPACITY];
  logic [lkvt_pkg::DATA_W-1:0]  val_mem [CAPACITY];
  logic [KW-1:0]                rd_key_q;
  logic [lkvt_pkg::DATA_W-1:0]  rd_val_q;
  logic                         rd_en, key_we, val_we;
  logic [AW-1:0]                rd_addr, wr_addr;
  logic [KW-1:0]                wr_key;
  logic [lkvt_pkg::DATA_W-1:0]  wr_val;

  assign ptr_next = ptr_q + CW'(1);
  assign ptr_prev = ptr_q - CW'(1);
  assign more     = (ptr_next < count_q);
  assign in_range = (ptr_q < count_q);
  assign match    = (rd_key_q == cur_q.key[KW-1:0]);

  always_comb begin
    state_d              = state_q;
    cur_d                = cur_q;
    ptr_d                = ptr_q;
    count_d              = count_q;
    rd_en                = 1'b0;
    rd_addr              = ptr_next[AW-1:0];
    key_we               = 1'b0;
    val_we               = 1'b0;
    wr_addr              = ptr_q[AW-1:0];
    wr_key               = cur_q.key[KW-1:0];
    wr_val               = cur_q.value;
    req_pop_o            = 1'b0;
    res_push_o           = 1'b0;
    res_o.status         = lkvt_pkg::ST_OK;
    res_o.out_value      = '0;
    res_o.out_key        = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i && !res_full_i) begin
          req_pop_o = 1'b1;
          cur_d     = req_i;
          ptr_d     = '0;
          rd_en     = 1'b1;
          if (req_i.search) begin
            rd_addr = '0;
            state_d = S_SCAN;
          end else begin
            rd_addr = AW'(req_i.index);
            state_d = S_READ;
          end
        end
      end
      S_SCAN: begin
        rd_en = more;
        if (in_range && match) begin
          case (cur_q.op)
            lkvt_pkg::OP_PUT: begin
              val_we     = 1'b1;
              res_push_o = 1'b1;
              state_d    = S_IDLE;
            end
            lkvt_pkg::OP_REMOVE: begin
              if (more) begin
                cur_d.value = rd_val_q;
                ptr_d       = ptr_next;
                state_d     = S_SHIFT;
              end else begin
                count_d         = count_q - CW'(1);
                res_o.out_value = rd_val_q;
                res_push_o      = 1'b1;
                state_d         = S_IDLE;
              end
            end
            default: begin
              res_o.out_value = rd_val_q;
              res_push_o      = 1'b1;
              state_d         = S_IDLE;
            end
          endcase
        end else if (more) begin
          ptr_d = ptr_next;
        end else begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
          if (cur_q.op == lkvt_pkg::OP_PUT) begin
            if (count_q == CW'(CAPACITY)) begin
              res_o.status = lkvt_pkg::ST_FULL;
            end else begin
              key_we  = 1'b1;
              val_we  = 1'b1;
              wr_addr = count_q[AW-1:0];
              count_d = count_q + CW'(1);
            end
          end else begin
            res_o.status = lkvt_pkg::ST_NOT_FOUND;
          end
        end
      end
      S_SHIFT: begin
        key_we  = 1'b1;
        val_we  = 1'b1;
        wr_addr = ptr_prev[AW-1:0];
        wr_key  = rd_key_q;
        wr_val  = rd_val_q;
        rd_en   = more;
        if (more) begin
          ptr_d = ptr_next;
        end else begin
          count_d         = count_q - CW'(1);
          res_o.out_value = cur_q.value;
          res_push_o      = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_READ: begin
        res_push_o = 1'b1;
        state_d    = S_IDLE;
        if (IW'(cur_q.index) < IW'(count_q)) begin
          res_o.out_value = rd_val_q;
          res_o.out_key   = lkvt_pkg::DATA_W'(rd_key_q);
        end else begin
          res_o.status = lkvt_pkg::ST_RANGE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    res_o.fill_count = lkvt_pkg::FILL_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[wr_addr] <= wr_key;
    if (val_we) val_mem[wr_addr] <= wr_val;
    if (rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_val_q <= val_mem[rd_addr];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(CAPACITY))
    else $error("Fill count exceeds the table capacity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(res_push_o && res_full_i))
    else $error("Result pushed into a full result queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (ptr_q != '0) && (ptr_q < count_q))
    else $error("Shift pointer outside the stored pairs.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && (res_o.status == lkvt_pkg::ST_FULL)) |-> (count_q == CW'(CAPACITY)))
    else $error("Put refused although the table has room.");

endmodule

[rtl/core/lkvt_result_queue.sv]
// ----------------------------------------------------------------------------
// lkvt_result_queue: result buffer
// Two-entry queue that holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module lkvt_result_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            res_push_i,
  input  lkvt_pkg::res_t  res_i,
  output logic            res_full_o,
  output logic            empty,
  input  logic            pop,
  output lkvt_pkg::res_t  res_o
);

  lkvt_pkg::res_t slot_q [2];
  logic [1:0]     used_q, used_d;
  logic           wr_q, rd_q;
  logic           do_push, do_pop;

  assign res_full_o = (used_q == 2'd2);
  assign empty      = (used_q == 2'd0);
  assign res_o      = slot_q[rd_q];
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop && !empty;
  assign used_d     = 2'(used_q + 2'(do_push) - 2'(do_pop));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 2'd0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
    end else begin
      used_q <= used_d;
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= res_i;
  end

endmodule

[tb/sv/tb_linear_key_value_table_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_key_value_table_top: self-checking bench of the key/value table
// A short table of directed requests covers the empty table, the extreme keys
// and values, value replacement, a table filled to capacity, the refused put,
// removal with shifting, and out-of-range reads. Random requests then grow and
// shrink the table, mostly from a small pool of keys. Every result is compared
// with the answer given in the directed table or with a model of the table
// kept inside the bench, while both queue sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_linear_key_value_table_top;
  import lkvt_pkg::*;

  localparam int SLOTS        = 16;
  localparam int RANDOM_ITEMS = 1150;
  localparam int PHASE_ITEMS  = 230;
  localparam int KEY_POOL     = 24;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DIRECTED_ROWS = 13;

  typedef struct {
    op_e                op;
    logic [DATA_W-1:0]  key;
    logic [DATA_W-1:0]  value;
    logic [INDEX_W-1:0] index;
    int                 span;
    bit                 typed;
    res_t               want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [1:0]          req_type_i = '0;
  logic [DATA_W-1:0]   key_i = '0;
  logic [DATA_W-1:0]   value_i = '0;
  logic [INDEX_W-1:0]  index_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [1:0]          status_o;
  logic [DATA_W-1:0]   out_value_o;
  logic [DATA_W-1:0]   out_key_o;
  logic [FILL_W-1:0]   fill_count_o;

  logic [DATA_W-1:0]   held_keys [SLOTS];
  logic [DATA_W-1:0]   held_values [SLOTS];
  int                  held_count = 0;
  res_t                expected_answers [$];
  logic [DATA_W-1:0]   key_pool [KEY_POOL];
  int                  status_seen [4] = '{0, 0, 0, 0};
  int                  mismatches = 0;
  int                  checked = 0;
  int                  cycle_count = 0;
  bit                  draining = 1'b0;

  // A span above one repeats the put with key and value stepping by one.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_READ,   32'h0,        32'h0,        4'd0,  1,  1'b1,
      '{ST_RANGE, 32'h0, 32'h0, 5'd0}},
    '{OP_REMOVE, 32'hFFFFFFFF, 32'h0,        4'd0,  1,  1'b1,
      '{ST_NOT_FOUND, 32'h0, 32'h0, 5'd0}},
    '{OP_PUT,    32'h0,        32'hFFFFFFFF, 4'd0,  1,  1'b1,
      '{ST_OK, 32'h0, 32'h0, 5'd1}},
    '{OP_PUT,    32'hFFFFFFFF, 32'h0,        4'd15, 1,  1'b1,
      '{ST_OK, 32'h0, 32'h0, 5'd2}},
    '{OP_READ,   32'h0,        32'h0,        4'd1,  1,  1'b1,
      '{ST_OK, 32'h0, 32'hFFFFFFFF, 5'd2}},
    '{OP_PUT,    32'h0,        32'h12345678, 4'd0,  1,  1'b1,
      '{ST_OK, 32'h0, 32'h0, 5'd2}},
    '{OP_GET,    32'h0,        32'h0,        4'd0,  1,  1'b1,
      '{ST_OK, 32'h12345678, 32'h0, 5'd2}},
    '{OP_PUT,    32'h100,      32'hA00,      4'd0,  14, 1'b0, '0},
    '{OP_PUT,    32'hDEADBEEF, 32'h1,        4'd0,  1,  1'b1,
      '{ST_FULL, 32'h0, 32'h0, 5'd16}},
    '{OP_PUT,    32'hFFFFFFFF, 32'hA5A5A5A5, 4'd0,  1,  1'b1,
      '{ST_OK, 32'h0, 32'h0, 5'd16}},
    '{OP_READ,   32'h0,        32'h0,        4'd15, 1,  1'b0, '0},
    '{OP_REMOVE, 32'h0,        32'h0,        4'd0,  1,  1'b1,
      '{ST_OK, 32'h12345678, 32'h0, 5'd15}},
    '{OP_READ,   32'h0,        32'h0,        4'd15, 1,  1'b1,
      '{ST_RANGE, 32'h0, 32'h0, 5'd15}}
  };

  linear_key_value_table_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .index_i      (index_i),
    .empty        (empty),
    .pop          (pop),
    .status_o     (status_o),
    .out_value_o  (out_value_o),
    .out_key_o    (out_key_o),
    .fill_count_o (fill_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic res_t table_answer(op_e op, logic [DATA_W-1:0] key,
                                        logic [DATA_W-1:0] value,
                                        logic [INDEX_W-1:0] idx);
    res_t ans;
    int   hit;
    ans = '0;
    ans.status = ST_OK;
    hit = -1;
    for (int i = 0; i < held_count; i++) begin
      if (hit < 0 && held_keys[i] == key) hit = i;
    end
    case (op)
      OP_PUT: begin
        if (hit >= 0) begin
          held_values[hit] = value;
        end else if (held_count >= SLOTS) begin
          ans.status = ST_FULL;
        end else begin
          held_keys[held_count] = key;
          held_values[held_count] = value;
          held_count++;
        end
      end
      OP_GET: begin
        if (hit >= 0) ans.out_value = held_values[hit];
        else ans.status = ST_NOT_FOUND;
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          ans.out_value = held_values[hit];
          for (int i = hit; i < held_count - 1; i++) begin
            held_keys[i] = held_keys[i + 1];
            held_values[i] = held_values[i + 1];
          end
          held_count--;
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (int'(idx) < held_count) begin
          ans.out_value = held_values[idx];
          ans.out_key = held_keys[idx];
        end else begin
          ans.status = ST_RANGE;
        end
      end
    endcase
    ans.fill_count = FILL_W'(held_count);
    return ans;
  endfunction

  function automatic op_e pick_op(bit shrinking);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < (shrinking ? 20 : 45)) return OP_PUT;
    if (roll < (shrinking ? 40 : 65)) return OP_GET;
    if (roll < (shrinking ? 80 : 80)) return OP_REMOVE;
    return OP_READ;
  endfunction

  function automatic logic [DATA_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, KEY_POOL - 1)];
    return $urandom;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_request(op_e op, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value,
                              logic [INDEX_W-1:0] idx, bit typed, res_t want);
    res_t predicted;
    push <= 1'b1;
    req_type_i <= op;
    key_i <= key;
    value_i <= value;
    index_i <= idx;
    do @(posedge clk_i); while (full);
    predicted = table_answer(op, key, value, idx);
    status_seen[predicted.status]++;
    expected_answers.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_answers.size());
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("result with no request waiting", out_value_o, '0);
        end else begin
          res_t want;
          want = expected_answers.pop_front();
          checked++;
          if (status_o !== want.status)
            report_mismatch("status", DATA_W'(status_o), DATA_W'(want.status));
          if (out_value_o !== want.out_value)
            report_mismatch("out_value", out_value_o, want.out_value);
          if (out_key_o !== want.out_key) report_mismatch("out_key", out_key_o, want.out_key);
          if (fill_count_o !== want.fill_count)
            report_mismatch("fill_count", DATA_W'(fill_count_o), DATA_W'(want.fill_count));
        end
      end
      if (draining) begin
        pop <= 1'b1;
      end else begin
        case (cycle_count[9:8])
          2'd0: pop <= 1'b1;
          2'd1: pop <= ($urandom_range(0, 9) < 7);
          2'd2: pop <= (cycle_count % 7 != 3) && (cycle_count % 5 != 0);
          default: pop <= (cycle_count[4:3] == 2'b11);
        endcase
      end
    end
  end

  initial begin
    int burst;
    int gap;
    int sent;
    int phase;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      for (int n = 0; n < directed_rows[r].span; n++) begin
        send_request(directed_rows[r].op, directed_rows[r].key + n,
                     directed_rows[r].value + n, directed_rows[r].index,
                     directed_rows[r].typed, directed_rows[r].want);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        send_request(pick_op(phase % 2 == 1), pick_key(), $urandom,
                     INDEX_W'($urandom_range(0, 15)), 1'b0, '0);
        sent++;
      end
      if (sent / PHASE_ITEMS != phase) begin
        // Hold off new requests until the table has answered everything so far.
        phase = sent / PHASE_ITEMS;
        push <= 1'b0;
        while (expected_answers.size() != 0) @(posedge clk_i);
      end else if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end

    push <= 1'b0;
    draining <= 1'b1;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("checked %0d results in %0d cycles", checked, cycle_count);
    $display("ok %0d, full %0d, not found %0d, out of range %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_FOUND],
             status_seen[ST_RANGE]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/lkvt_pkg.sv
rtl/core/lkvt_front.sv
rtl/core/lkvt_back.sv
rtl/core/lkvt_result_queue.sv
rtl/core/linear_key_value_table_top.sv
tb/sv/tb_linear_key_value_table_top.sv
